// File: hw/rtl/swtb_pkg.sv
package swtb_pkg;

	localparam int unsigned NUM_TIMERS_DEF = 8;
	localparam int unsigned MAX_TIMERS = 8;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned ID_W = 3;

	// operation codes carried in the request word
	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// per-timer life cycle, also reported in the response word
	typedef enum logic [1:0] {
		ST_STOPPED = 2'd0,
		ST_RUNNING = 2'd1,
		ST_TIMEOUT = 2'd2
	} tstate_t;

	typedef struct packed {
		op_t               mode;
		logic [ID_W-1:0]   timer_id;
		logic              periodic;
		logic [TICK_W-1:0] delay;
		logic [TICK_W-1:0] now;
	} swtb_req_t;

	typedef struct packed {
		logic [MAX_TIMERS-1:0] fired_mask;
		tstate_t               timer_status;
	} swtb_rsp_t;

endpackage

// File: hw/rtl/swtb_alu.sv
// Shared arithmetic unit: due check and re-arm adder for one timer per cycle.
module swtb_alu (
	input  logic [swtb_pkg::TICK_W-1:0] cmp_val,
	input  logic [swtb_pkg::TICK_W-1:0] add_val,
	input  logic [swtb_pkg::TICK_W-1:0] now,
	output logic                        due,
	output logic [swtb_pkg::TICK_W-1:0] sum
);
	import swtb_pkg::*;

	// plain unsigned compare, no wrap window
	assign due = (cmp_val <= now);
	// modulo 2^32 add
	assign sum = now + add_val;

endmodule

// File: hw/rtl/software_timer_bank.sv
// Sequence: an update visits every timer in S_WALK (one timer visited per cycle
//   by the shared adder/comparator), then S_STATUS registers the response.
// Start, stop: S_OP then S_STATUS; query, or start/stop with out-of-range id: S_STATUS.
// Throughput: one word at a time; req_ready is high only while idle, so a new
//   request is taken only after the response has been accepted.
// Reset: arst_n asynchronous; all timers stopped and one-shot, no response.
module software_timer_bank #(
	parameter int unsigned NUM_TIMERS = swtb_pkg::NUM_TIMERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  swtb_pkg::swtb_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output swtb_pkg::swtb_rsp_t rsp
);
	import swtb_pkg::*;

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_OP,
		S_STATUS,
		S_OUT
	} fsm_t;

	fsm_t                  state_q;
	swtb_req_t             req_q;
	logic                  id_ok_q;
	logic [IDX_W-1:0]      idx_q;
	logic [MAX_TIMERS-1:0] fired_q;
	swtb_rsp_t             rsp_q;
	logic                  rsp_valid_q;

	tstate_t               run_q    [NUM_TIMERS];
	logic                  repeat_q [NUM_TIMERS];
	logic [TICK_W-1:0]     deadline_q [NUM_TIMERS];
	logic [TICK_W-1:0]     period_q   [NUM_TIMERS];

	logic                  req_fire;
	logic                  id_ok;
	logic [IDX_W-1:0]      id_idx;
	logic [TICK_W-1:0]     add_val;
	logic                  due;
	logic [TICK_W-1:0]     sum;
	logic                  wr_deadline;
	logic                  wr_period;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign id_ok  = ({1'b0, req.timer_id} < (ID_W + 1)'(NUM_TIMERS));
	assign id_idx = IDX_W'(req.timer_id);

	// shared unit operand select: reload period while walking, delay on start
	assign add_val = (state_q == S_WALK) ? period_q[idx_q] : req_q.delay;

	swtb_alu u_alu (
		.cmp_val (deadline_q[idx_q]),
		.add_val (add_val),
		.now     (req_q.now),
		.due     (due),
		.sum     (sum)
	);

	// deadline/period write enables for the payload store
	always_comb begin
		wr_deadline = 1'b0;
		wr_period   = 1'b0;
		if (state_q == S_WALK && run_q[idx_q] == ST_RUNNING && due) begin
			wr_deadline = 1'b1;
		end
		if (state_q == S_OP && id_ok_q && req_q.mode == OP_START) begin
			wr_deadline = 1'b1;
			wr_period   = 1'b1;
		end
	end

	// payload store, no reset needed: read only after a start has written it
	always_ff @(posedge clk) begin
		if (wr_deadline) begin
			deadline_q[idx_q] <= sum;
		end
		if (wr_period) begin
			period_q[idx_q] <= req_q.delay;
		end
	end

	// sequencer, timer state and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			id_ok_q     <= 1'b0;
			idx_q       <= '0;
			fired_q     <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				run_q[i]    <= ST_STOPPED;
				repeat_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						req_q   <= req;
						id_ok_q <= id_ok;
						fired_q <= '0;
						unique case (req.mode)
							OP_UPDATE: begin
								idx_q   <= '0;
								state_q <= S_WALK;
							end
							OP_START, OP_STOP: begin
								idx_q   <= id_idx;
								state_q <= id_ok ? S_OP : S_STATUS;
							end
							OP_QUERY: begin
								idx_q   <= id_idx;
								state_q <= S_STATUS;
							end
							default: state_q <= S_STATUS;
						endcase
					end
				end
				S_WALK: begin
					// one timer per cycle
					priority case (run_q[idx_q])
						ST_RUNNING: begin
							if (due) begin
								run_q[idx_q] <= ST_TIMEOUT;
								fired_q <= fired_q | (MAX_TIMERS'(1) << idx_q);
							end
						end
						ST_TIMEOUT: begin
							run_q[idx_q] <= repeat_q[idx_q] ? ST_RUNNING : ST_STOPPED;
						end
						default: ;
					endcase
					if (idx_q == LAST_IDX) begin
						idx_q   <= IDX_W'(req_q.timer_id);
						state_q <= S_STATUS;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_OP: begin
					if (req_q.mode == OP_START) begin
						run_q[idx_q]    <= ST_RUNNING;
						repeat_q[idx_q] <= req_q.periodic;
					end else begin
						run_q[idx_q] <= ST_STOPPED;
					end
					state_q <= S_STATUS;
				end
				S_STATUS: begin
					rsp_q.fired_mask   <= fired_q;
					rsp_q.timer_status <= id_ok_q ? run_q[idx_q] : ST_STOPPED;
					rsp_valid_q        <= 1'b1;
					state_q            <= S_OUT;
				end
				S_OUT: begin
					if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/swtb_checker.sv
// Port-level checks for the timer bank.
module swtb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input swtb_pkg::swtb_rsp_t rsp
);
	import swtb_pkg::*;

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// the bank works on one word at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a response is pending");

	// after a request is taken the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready && !rsp_valid)
		else $error("not busy after accepting a request");

	// reported status is never an unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.timer_status == ST_STOPPED ||
			rsp.timer_status == ST_RUNNING || rsp.timer_status == ST_TIMEOUT))
		else $error("illegal timer status code");

endmodule

bind software_timer_bank swtb_checker u_swtb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
